// ===== sv/pcg_pkg.sv =====
// Shared types, calibration table and grading function for the particulate calibrate block.
package pcg_pkg;

   localparam int unsigned SegCount = 13;

   localparam logic [12:0] DUTY_SAT      = 13'd5000;
   localparam logic [16:0] CAL_CAP       = 17'd120000;
   localparam logic [9:0]  DISPLAY_MAX   = 10'd1023;
   // Reciprocal constants: x*6554 >> 16 is x/10 and t*167773 >> 24 is t/100 over the
   // ranges used here.
   localparam logic [12:0] RECIP_TEN     = 13'd6554;
   localparam logic [17:0] RECIP_HUNDRED = 18'd167773;

   localparam logic [11:0] SEG_TOP [SegCount] = '{
      12'd100, 12'd130, 12'd230, 12'd460, 12'd580, 12'd860, 12'd1200,
      12'd1390, 12'd1680, 12'd1950, 12'd2200, 12'd2360, 12'd2500};
   localparam logic [7:0] SEG_MUL [SegCount] = '{
      8'd40, 8'd33, 8'd10, 8'd4, 8'd17, 8'd11, 8'd18,
      8'd63, 8'd52, 8'd70, 8'd64, 8'd100, 8'd136};
   localparam logic signed [19:0] SEG_ADD [SegCount] = '{
      20'sd0, 20'sd700, 20'sd3700, 20'sd5000, -20'sd700, 20'sd2800, -20'sd3200,
      -20'sd57800, -20'sd41900, -20'sd73200, -20'sd60800, -20'sd140000, -20'sd224300};

   typedef struct packed {
      logic [13:0] duty;
      logic [9:0]  outside_pm;
      logic        outside_valid;
   } req_type;

   typedef struct packed {
      logic [9:0] display_pm;
      logic [2:0] grade;
      logic [8:0] duty_tenths;
   } rsp_type;

   // Calibrated and adjusted value handed from the front end to the back end.
   typedef struct packed {
      logic [10:0] value;
      logic [8:0]  duty_tenths;
   } work_type;

   typedef struct packed {
      logic [3:0] index;
      logic       above;
   } seg_sel_type;

   function automatic seg_sel_type seg_select(input logic [12:0] x);
      seg_sel_type sel;
      sel.index = 4'(SegCount - 1);
      sel.above = (x > 13'(SEG_TOP[SegCount - 1]));
      for (int i = SegCount - 1; i >= 0; i--) begin
         if (x <= 13'(SEG_TOP[i])) begin
            sel.index = 4'(i);
         end
      end
      return sel;
   endfunction

   // Six-level grade with hysteresis; once graded, moves at most one level per report.
   function automatic logic [2:0] next_grade(input logic [9:0] d, input logic [2:0] l);
      logic [2:0] g;
      if (d <= 10'd50) begin
         if (l <= 3'd1) g = 3'd1;
         else if (l == 3'd2) g = (d <= 10'd45) ? 3'd1 : 3'd2;
         else g = l - 3'd1;
      end else if (d <= 10'd100) begin
         if (l <= 3'd1) g = (d <= 10'd55) ? 3'd1 : 3'd2;
         else if (l == 3'd2) g = 3'd2;
         else if (l == 3'd3) g = (d <= 10'd95) ? 3'd2 : 3'd3;
         else g = l - 3'd1;
      end else if (d <= 10'd150) begin
         if (l <= 3'd1) g = l + 3'd1;
         else if (l == 3'd2) g = (d <= 10'd105) ? 3'd2 : 3'd3;
         else if (l == 3'd3) g = 3'd3;
         else if (l == 3'd4) g = (d <= 10'd145) ? 3'd3 : 3'd4;
         else g = l - 3'd1;
      end else if (d <= 10'd200) begin
         if (l <= 3'd2) g = l + 3'd1;
         else if (l == 3'd3) g = (d <= 10'd155) ? 3'd3 : 3'd4;
         else if (l == 3'd4) g = 3'd4;
         else if (l == 3'd5) g = (d <= 10'd195) ? 3'd4 : 3'd5;
         else g = l - 3'd1;
      end else if (d <= 10'd300) begin
         if (l <= 3'd3) g = l + 3'd1;
         else if (l == 3'd4) g = (d <= 10'd205) ? 3'd4 : 3'd5;
         else if (l == 3'd5) g = 3'd5;
         else if (l == 3'd6) g = (d <= 10'd295) ? 3'd5 : 3'd6;
         else g = l;
      end else begin
         if (l <= 3'd4) g = l + 3'd1;
         else if (l == 3'd5) g = (d <= 10'd305) ? 3'd5 : 3'd6;
         else g = l;
      end
      if (g > 3'd6) g = 3'd6;
      return g;
   endfunction

endpackage

// ===== sv/pcg_front.sv =====
// Front end: accepts reports, calibrates the duty and applies the outside-reading adjustment.
module pcg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcg_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output pcg_pkg::work_type push_data
);
   import pcg_pkg::*;

   function automatic logic [10:0] adjust(input logic [10:0] v_in, input logic [9:0] o_in);
      logic [10:0] v;
      logic [10:0] o;
      logic [10:0] d;
      v = v_in;
      o = {1'b0, o_in};
      if (o > v && (o - v) <= 11'd5 && o > 11'd5) v = o - 11'd5;
      d = v - o;
      if (v > o) begin
         if (d < 11'd3) begin
            if (v > 11'd3) v = v - 11'd3;
         end else if (d <= 11'd15) begin
            if (v > 11'd8) v = v - 11'd8;
            else v = o;
         end else begin
            v = v - 11'd15;
         end
      end
      return v;
   endfunction

   // Stage one: segment multiply and clamp.
   logic        s1_valid_ff, s1_valid_in;
   logic [16:0] s1_cal_ff, s1_cal_in;
   logic [8:0]  s1_tenths_ff, s1_tenths_in;
   logic [9:0]  s1_opm_ff;
   logic        s1_ok_ff;
   // Stage two: divide by one hundred.
   logic        s2_valid_ff, s2_valid_in;
   logic [10:0] s2_value_ff, s2_value_in;
   logic [8:0]  s2_tenths_ff;
   logic [9:0]  s2_opm_ff;
   logic        s2_ok_ff;

   logic        s1_move, s2_move;
   logic [12:0] x_sat;
   seg_sel_type sel;
   logic [20:0] prod;
   logic signed [21:0] t_wide;
   logic [25:0] tenths_prod;
   logic [34:0] hundred_prod;

   assign s2_move   = !s2_valid_ff || push_ready;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_ready = s1_move;

   always_comb begin
      x_sat = (req_data.duty > 14'(DUTY_SAT)) ? DUTY_SAT : req_data.duty[12:0];
      sel   = seg_select(x_sat);
      prod  = 21'(x_sat) * 21'(SEG_MUL[sel.index]);
      t_wide = $signed({1'b0, prod}) + 22'(SEG_ADD[sel.index]);
      if (sel.above || t_wide > 22'sd120000) begin
         s1_cal_in = CAL_CAP;
      end else if (t_wide < 22'sd0) begin
         s1_cal_in = 17'd0;
      end else begin
         s1_cal_in = t_wide[16:0];
      end
      tenths_prod  = 26'(x_sat) * 26'(RECIP_TEN);
      s1_tenths_in = tenths_prod[24:16];
      s1_valid_in  = s1_move ? req_valid : s1_valid_ff;

      hundred_prod = 35'(s1_cal_ff) * 35'(RECIP_HUNDRED);
      s2_value_in  = hundred_prod[34:24];
      s2_valid_in  = s2_move ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_move) begin
         s1_cal_ff    <= s1_cal_in;
         s1_tenths_ff <= s1_tenths_in;
         s1_opm_ff    <= req_data.outside_pm;
         s1_ok_ff     <= req_data.outside_valid;
      end
      if (s2_move) begin
         s2_value_ff  <= s2_value_in;
         s2_tenths_ff <= s1_tenths_ff;
         s2_opm_ff    <= s1_opm_ff;
         s2_ok_ff     <= s1_ok_ff;
      end
   end

   assign push_valid            = s2_valid_ff;
   assign push_data.value       = s2_ok_ff ? adjust(s2_value_ff, s2_opm_ff) : s2_value_ff;
   assign push_data.duty_tenths = s2_tenths_ff;

endmodule

// ===== sv/pcg_fifo.sv =====
// Two-entry queue between the front end and the back end.
module pcg_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pcg_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pcg_pkg::work_type pop_data
);
   import pcg_pkg::*;

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/pcg_back.sv =====
// Back end: slew limiting, grading, startup blanking and the result register.
module pcg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        blank_reports,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  pcg_pkg::work_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcg_pkg::rsp_type  rsp_data
);
   import pcg_pkg::*;

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic [9:0] prev_display_ff, prev_display_in;
   logic [2:0] prev_grade_ff, prev_grade_in;
   logic [1:0] reports_done_ff, reports_done_in;

   logic        fire, up, blank;
   logic [10:0] diff;
   logic [23:0] diff_prod;
   logic [8:0]  step;
   logic [11:0] raised;
   logic [9:0]  disp;
   logic [2:0]  grade;

   assign pop_ready = !out_valid_ff || rsp_ready;
   assign fire      = pop_valid && pop_ready;

   always_comb begin
      up        = pop_data.value > {1'b0, prev_display_ff};
      diff      = up ? pop_data.value - {1'b0, prev_display_ff}
                     : {1'b0, prev_display_ff} - pop_data.value;
      diff_prod = 24'(diff) * 24'(RECIP_TEN);
      step      = {1'b0, diff_prod[23:16]} + 9'd1;
      raised    = {2'b00, prev_display_ff} + 12'(step);
      if (diff == 11'd0) begin
         disp = prev_display_ff;
      end else if (up) begin
         disp = (raised > 12'(DISPLAY_MAX)) ? DISPLAY_MAX : raised[9:0];
      end else begin
         disp = prev_display_ff - step[9:0];
      end
      grade = next_grade(disp, prev_grade_ff);
      blank = reports_done_ff < blank_reports;

      out_in.display_pm  = blank ? 10'd0 : disp;
      out_in.grade       = grade;
      out_in.duty_tenths = pop_data.duty_tenths;

      out_valid_in    = fire || (out_valid_ff && !rsp_ready);
      prev_display_in = fire ? out_in.display_pm : prev_display_ff;
      prev_grade_in   = fire ? grade : prev_grade_ff;
      reports_done_in = (fire && blank) ? reports_done_ff + 2'd1 : reports_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         prev_display_ff <= 10'd0;
         prev_grade_ff   <= 3'd0;
         reports_done_ff <= 2'd0;
      end else begin
         out_valid_ff    <= out_valid_in;
         prev_display_ff <= prev_display_in;
         prev_grade_ff   <= prev_grade_in;
         reports_done_ff <= reports_done_in;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_grade_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.grade >= 3'd1 && out_ff.grade <= 3'd6))
      else $error("grade out of range");
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      (fire && reports_done_ff < blank_reports) |=> (out_ff.display_pm == 10'd0))
      else $error("display not blanked during startup");
   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      fire |=> (prev_display_ff == out_ff.display_pm && prev_grade_ff == out_ff.grade))
      else $error("stored state differs from delivered result");
`endif

endmodule

// ===== sv/particulate_calibrate_and_grade.sv =====
// Top level of the particulate calibrate and grade block.
// Takes one report per cycle while results are taken and delivers one result per
// report, in order. A report passes two front-end stages (segment multiply, then
// divide by one hundred and the outside-reading adjustment), a two-entry queue and
// the back end's result register before its result is offered. The sustained rate
// is set by the back end, which updates the previous display value and grade for each
// report it takes. The user must write the blanking register through csr_wr_en and
// csr_wr_data only while the block is idle; the block itself does not enforce it.
module particulate_calibrate_and_grade (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcg_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);
   import pcg_pkg::*;

   logic [1:0] blank_reports_ff, blank_reports_in;
   logic       push_valid, push_ready, pop_valid, pop_ready;
   work_type   push_data, pop_data;

   assign blank_reports_in = csr_wr_en ? csr_wr_data : blank_reports_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_reports_ff <= 2'd3;
      end else begin
         blank_reports_ff <= blank_reports_in;
      end
   end

   pcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pcg_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pcg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .blank_reports (blank_reports_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== tb/pcg_report_checker.sv =====
// Checker for the particulate calibrate and grade block: predicts each report and compares results.
module pcg_report_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pcg_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pcg_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data,
   output int               fail_count,
   output int               outstanding,
   output int               checked_count
);

   localparam int DutyLimit  = 5000;
   localparam int CalibCap   = 120000;
   localparam int DisplayTop = 1023;

   pcg_pkg::rsp_type predicted_reports [$];

   logic [9:0] last_display;
   logic [2:0] last_grade;
   logic [1:0] blanked_so_far;
   logic [1:0] blank_limit;
   int         mismatch_count = 0;
   int         result_count = 0;
   int         queued_count = 0;

   assign fail_count    = mismatch_count;
   assign outstanding   = queued_count;
   assign checked_count = result_count;

   // Piecewise-linear calibration in hundredths, capped, then in whole units.
   function automatic int calibrated_pm(input int x);
      int t;
      if (x <= 100)       t = x * 40;
      else if (x <= 130)  t = x * 33 + 700;
      else if (x <= 230)  t = x * 10 + 3700;
      else if (x <= 460)  t = x * 4 + 5000;
      else if (x <= 580)  t = x * 17 - 700;
      else if (x <= 860)  t = x * 11 + 2800;
      else if (x <= 1200) t = x * 18 - 3200;
      else if (x <= 1390) t = x * 63 - 57800;
      else if (x <= 1680) t = x * 52 - 41900;
      else if (x <= 1950) t = x * 70 - 73200;
      else if (x <= 2200) t = x * 64 - 60800;
      else if (x <= 2360) t = x * 100 - 140000;
      else if (x <= 2500) t = x * 136 - 224300;
      else                t = CalibCap;
      if (t > CalibCap) t = CalibCap;
      if (t < 0) t = 0;
      return t / 100;
   endfunction

   // Pulls the calibrated value toward the outside reading.
   function automatic int nudged_pm(input int v, input int o);
      int gap;
      if (o - v > 0 && o - v <= 5 && o > 5) v = o - 5;
      if (v > o) begin
         gap = v - o;
         if (gap < 3) begin
            if (v > 3) v = v - 3;
         end else if (gap <= 15) begin
            if (v > 8) v = v - 8;
            else v = o;
         end else begin
            v = v - 15;
         end
      end
      return v;
   endfunction

   // Each band has an edge at or below which a level coming up from beneath stays put,
   // and an edge at or below which a level coming down from above drops into the band.
   function automatic logic [2:0] graded_level(input int d, input int prev);
      int band;
      int rise_edge;
      int fall_edge;
      int l;
      int g;
      if (d <= 50)       band = 1;
      else if (d <= 100) band = 2;
      else if (d <= 150) band = 3;
      else if (d <= 200) band = 4;
      else if (d <= 300) band = 5;
      else               band = 6;
      case (band)
         1: begin rise_edge = 0;   fall_edge = 45;  end
         2: begin rise_edge = 55;  fall_edge = 95;  end
         3: begin rise_edge = 105; fall_edge = 145; end
         4: begin rise_edge = 155; fall_edge = 195; end
         5: begin rise_edge = 205; fall_edge = 295; end
         default: begin rise_edge = 305; fall_edge = 0; end
      endcase
      l = prev;
      // An ungraded start in the second band behaves like level one.
      if (band == 2 && l == 0) l = 1;
      if (l == band) begin
         g = l;
      end else if (l < band) begin
         if (band > 1 && l == band - 1) g = (d <= rise_edge) ? l : band;
         else g = l + 1;
      end else if (band == 6) begin
         g = 6;
      end else if (l == band + 1) begin
         g = (d <= fall_edge) ? band : l;
      end else begin
         g = l - 1;
      end
      return 3'(g);
   endfunction

   task automatic predict_report(input pcg_pkg::req_type r);
      pcg_pkg::rsp_type res;
      int x;
      int v;
      int p;
      int shown;
      logic [2:0] level;
      x = (r.duty > DutyLimit) ? DutyLimit : int'(r.duty);
      v = calibrated_pm(x);
      if (r.outside_valid) v = nudged_pm(v, int'(r.outside_pm));
      p = int'(last_display);
      if (v > p)      shown = p + (v - p) / 10 + 1;
      else if (v < p) shown = p - ((p - v) / 10 + 1);
      else            shown = p;
      if (shown > DisplayTop) shown = DisplayTop;
      if (shown < 0) shown = 0;
      level = graded_level(shown, int'(last_grade));
      // Grading sees the real value even while the display is still blanked.
      if (blanked_so_far < blank_limit) begin
         blanked_so_far = blanked_so_far + 2'd1;
         shown = 0;
      end
      last_display = 10'(shown);
      last_grade = level;
      res.display_pm = 10'(shown);
      res.grade = level;
      res.duty_tenths = 9'(x / 10);
      predicted_reports.push_back(res);
   endtask

   task automatic check_report(input pcg_pkg::rsp_type got);
      pcg_pkg::rsp_type want;
      result_count++;
      if (predicted_reports.size() == 0) begin
         $display("%0t: result with no report pending: display_pm %0d grade %0d duty_tenths %0d",
                  $time, got.display_pm, got.grade, got.duty_tenths);
         mismatch_count++;
      end else begin
         want = predicted_reports.pop_front();
         if (got.display_pm !== want.display_pm) begin
            $display("%0t: display_pm mismatch, expected %0d, got %0d",
                     $time, want.display_pm, got.display_pm);
            mismatch_count++;
         end
         if (got.grade !== want.grade) begin
            $display("%0t: grade mismatch, expected %0d, got %0d", $time, want.grade, got.grade);
            mismatch_count++;
         end
         if (got.duty_tenths !== want.duty_tenths) begin
            $display("%0t: duty_tenths mismatch, expected %0d, got %0d",
                     $time, want.duty_tenths, got.duty_tenths);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         blank_limit = 2'd3;
         last_display = '0;
         last_grade = '0;
         blanked_so_far = '0;
         predicted_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_report(rsp_data);
         if (csr_wr_en) blank_limit = csr_wr_data;
         if (req_valid && req_ready) predict_report(req_data);
      end
      queued_count = predicted_reports.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, report stimulus, result stalls and the verdict.
module testbench;

   localparam int CycleLimit      = 500000;
   localparam int PhaseCount      = 8;
   localparam int ReportsPerPhase = 210;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pcg_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pcg_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [1:0]       csr_wr_data = '0;

   bit hold_request = 1'b0;
   int cycle_count = 0;
   int sent_count = 0;
   int fail_count;
   int outstanding;
   int checked_count;

   particulate_calibrate_and_grade u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pcg_report_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: switches between stall patterns on its own, and honors a long hold-off.
   initial begin
      int         mode = 0;
      int         mode_left = 0;
      int         hold_left = 0;
      logic [7:0] ready_pattern = 8'b1011_0010;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = $urandom_range(60, 120);
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 9) < 7);
               2: rsp_ready <= ready_pattern[0];
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_report(input pcg_pkg::req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_fields(input int duty, input int outside, input bit usable);
      pcg_pkg::req_type r;
      r.duty = 14'(duty);
      r.outside_pm = 10'(outside);
      r.outside_valid = usable;
      send_report(r);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_blank_limit(input logic [1:0] limit);
      drain_reports();
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly reports hovering around a duty center; some in the lowest segment with an
   // outside reading close to the calibrated value, and some fully random.
   function automatic pcg_pkg::req_type random_report(input int centre);
      pcg_pkg::req_type r;
      int pick;
      int duty;
      int outside;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.duty = 14'($urandom_range(0, 16383));
         r.outside_pm = 10'($urandom_range(0, 1023));
         r.outside_valid = 1'($urandom_range(0, 1));
      end else if (pick < 35) begin
         duty = $urandom_range(0, 100);
         outside = duty * 2 / 5 + $urandom_range(0, 26) - 18;
         if (outside < 0) outside = 0;
         r.duty = 14'(duty);
         r.outside_pm = 10'(outside);
         r.outside_valid = ($urandom_range(0, 7) != 0);
      end else begin
         duty = centre + $urandom_range(0, 80) - 40;
         if (duty < 0) duty = 0;
         if (duty > 16383) duty = 16383;
         r.duty = 14'(duty);
         r.outside_pm = 10'($urandom_range(0, 1023));
         r.outside_valid = ($urandom_range(0, 4) == 0);
      end
      return r;
   endfunction

   initial begin
      int phase;
      int sent_in_phase;
      int burst;
      int gap;
      int centre;
      int pick;
      bit held;
      bit want_hold;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // The reset blanking limit hides the first reports.
      send_fields(0, 0, 1'b0);
      send_fields(16383, 1023, 1'b1);
      write_blank_limit(2'd0);
      send_fields(100, 43, 1'b1);   // outside slightly above: pulled to five below it
      send_fields(100, 45, 1'b1);
      send_fields(0, 4, 1'b1);      // small outside reading is never a target
      send_fields(100, 39, 1'b1);   // just above outside
      send_fields(5, 1, 1'b1);      // just above, but too small to lower
      send_fields(100, 30, 1'b1);   // moderately above
      send_fields(20, 3, 1'b1);     // moderately above and small: snaps to outside
      send_fields(100, 0, 1'b1);    // far above
      send_fields(5000, 1023, 1'b1);
      send_fields(2500, 0, 1'b0);
      send_fields(2501, 0, 1'b0);
      send_fields(5001, 0, 1'b0);
      send_fields(10000, 512, 1'b0);
      send_fields(8192, 0, 1'b0);
      send_fields(101, 0, 1'b0);
      send_fields(130, 0, 1'b0);
      send_fields(460, 0, 1'b0);
      send_fields(1201, 0, 1'b0);
      send_fields(1680, 0, 1'b0);
      send_fields(0, 0, 1'b0);

      for (phase = 0; phase < PhaseCount; phase++) begin
         write_blank_limit(2'((phase * 3 + 1) % 4));
         sent_in_phase = 0;
         held = 1'b0;
         while (sent_in_phase < ReportsPerPhase) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)      centre = $urandom_range(0, 1700);
            else if (pick < 8) centre = $urandom_range(1700, 2700);
            else               centre = $urandom_range(2700, 16383);
            burst = $urandom_range(1, 24);
            want_hold = 1'b0;
            // Halfway through, hold off the results and keep offering reports.
            if (!held && sent_in_phase >= ReportsPerPhase / 2) begin
               held = 1'b1;
               want_hold = 1'b1;
               burst = 16;
            end
            repeat (burst) begin
               send_report(random_report(centre));
               sent_in_phase++;
               if (want_hold) begin
                  hold_request = 1'b1;
                  want_hold = 1'b0;
               end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) pause_sender(gap);
         end
      end

      drain_reports();
      repeat (8) @(negedge clock);
      $display("Covered %0d reports and %0d results: all blanking limits, outside adjustment,",
               sent_count, checked_count);
      $display("slew and grade hysteresis, under bursts, gaps and long result stalls.");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
